### hdl/ipet_pkg.sv
// Shared types and constants for the infrared port edge timeline unit.
package ipet_pkg;

  localparam int REQ_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int CYCLE_W = 31;
  localparam int CFG_W   = 16;
  localparam int SKEW_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 48;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RECOG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKEW    = 2'd2;

  localparam logic [SKEW_W-1:0] SKEW_RESET = 4'd4;

  localparam logic [BYTE_W-1:0] READ_OR_LIGHT = 8'h3C;
  localparam logic [BYTE_W-1:0] READ_OR_IDLE  = 8'h3E;

  typedef struct packed {
    logic neg;
    logic zero;
  } alu_flags_t;

endpackage

### hdl/ipet_alu.sv
// Shared add/subtract unit used by the timeline sequencer.
module ipet_alu #(
  parameter int WIDTH = 34
) (
  input  logic [WIDTH-1:0]    a,
  input  logic [WIDTH-1:0]    b,
  input  logic                sub,
  output logic [WIDTH-1:0]    res,
  output ipet_pkg::alu_flags_t flags
);

  assign res = sub ? (a - b) : (a + b);

  // operands stay below half the range, so the top bit is the borrow
  assign flags.neg  = res[WIDTH-1];
  assign flags.zero = (res == '0);

endmodule

### hdl/infrared_port_edge_timeline_unit.sv
// Infrared port register with timestamped edge queue and playback sequencer.
// A write or unused request goes straight to the output stage; a read first checks the
// current signal and the queue head, and a partner edge first closes and pushes a queue entry.
// One item at a time: the shared add/subtract unit and the registered queue read
// port serialise the steps. A result waits in the output register while the next beat
// is taken. Synchronous reset clears the register, playback state and queue pointers.
module infrared_port_edge_timeline_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // req_type
  input  logic [ipet_pkg::REQ_W-1:0]           s_tuser,
  // write_value[7:0], cycle_now[38:8], edge_light[39]
  input  logic [ipet_pkg::S_DATA_W-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // read_data[7:0], edge_out_valid[8], edge_out_light[9], edge_out_cycle[40:10],
  // queue_overflow[41], zero[47:42]
  output logic [ipet_pkg::M_DATA_W-1:0]        m_tdata,
  input  logic                                 cfg_we,
  input  logic [ipet_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ipet_pkg::CFG_W-1:0]           cfg_data
);

  localparam int TW = TIME_WIDTH;
  localparam int AW = TIME_WIDTH + 2;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = QW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [QW-1:0] LAST_Q  = QW'(QUEUE_DEPTH - 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_E_SUM   = 4'd1;
  localparam logic [3:0] ST_E_SKEW  = 4'd2;
  localparam logic [3:0] ST_E_STOP  = 4'd3;
  localparam logic [3:0] ST_E_CLOSE = 4'd4;
  localparam logic [3:0] ST_E_PUSH  = 4'd5;
  localparam logic [3:0] ST_A_END   = 4'd6;
  localparam logic [3:0] ST_A_CHKC  = 4'd7;
  localparam logic [3:0] ST_A_CHKH  = 4'd8;
  localparam logic [3:0] ST_L_ISSUE = 4'd9;
  localparam logic [3:0] ST_L_TEST  = 4'd10;
  localparam logic [3:0] ST_L_END   = 4'd11;
  localparam logic [3:0] ST_L_CHK   = 4'd12;
  localparam logic [3:0] ST_R_FIN   = 4'd13;
  localparam logic [3:0] ST_DONE    = 4'd14;

  // configuration
  logic [ipet_pkg::CFG_W-1:0]  recog;
  logic [ipet_pkg::CFG_W-1:0]  fadeout;
  logic [ipet_pkg::SKEW_W-1:0] skew;

  // control and playback state
  logic [3:0]    state;
  logic [ipet_pkg::REQ_W-1:0] req;
  logic [ipet_pkg::BYTE_W-1:0] port_reg;
  logic          cur_valid;
  logic          cur_light;
  logic [TW-1:0] cur_start;
  logic [TW-1:0] cur_dur;
  logic [QW-1:0] head;
  logic [CW-1:0] count;
  logic          exp_flag;

  // item payload and working values
  logic [TW-1:0] now_r;
  logic          light_r;
  logic [TW:0]   tmp;
  logic [TW-1:0] start_r;

  // result payload
  logic [ipet_pkg::BYTE_W-1:0]  res_rdata;
  logic                         res_ev;
  logic                         res_el;
  logic [ipet_pkg::CYCLE_W-1:0] res_ec;
  logic                         res_ovf;

  // queue memory
  logic          mem_light [QUEUE_DEPTH];
  logic [TW-1:0] mem_start [QUEUE_DEPTH];
  logic [TW-1:0] mem_dur   [QUEUE_DEPTH];
  logic          rd_light;
  logic [TW-1:0] rd_start;
  logic [TW-1:0] rd_dur;
  logic          rd_en;
  logic [QW-1:0] rd_addr;
  logic          wr_en;
  logic [QW-1:0] wr_addr;
  logic          wr_light;
  logic [TW-1:0] wr_start;
  logic [TW-1:0] wr_dur;

  // shared unit
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic          alu_sub;
  logic [AW-1:0] alu_res;
  ipet_pkg::alu_flags_t alu_flags;

  // queue slots
  logic [QW-1:0] head_inc;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] last_sum;
  logic [QW-1:0] tail_slot;
  logic [QW-1:0] last_slot;

  // input fields
  logic [ipet_pkg::BYTE_W-1:0]  in_wval;
  logic [ipet_pkg::CYCLE_W-1:0] in_cycle;
  logic                         in_light;
  logic [ipet_pkg::BYTE_W-1:0]  wr_next;
  logic                         led_toggle;

  logic [TW-1:0] close_dur;
  logic          close_pend;
  logic          close_cur;
  logic          read_light_mode;
  logic          read_level;

  assign in_wval  = s_tdata[7:0];
  assign in_cycle = s_tdata[38:8];
  assign in_light = s_tdata[39];
  assign wr_next  = {in_wval[7:2], port_reg[1], in_wval[0]};
  assign led_toggle = (s_tuser == ipet_pkg::REQ_WRITE) && (wr_next[0] != port_reg[0]);

  assign s_tready = (state == ST_IDLE);

  assign head_inc  = (head == LAST_Q) ? '0 : head + 1'b1;
  assign tail_sum  = SW'(head) + SW'(count);
  assign last_sum  = tail_sum - 1'b1;
  assign tail_slot = (tail_sum >= DEPTH_S) ? QW'(tail_sum - DEPTH_S) : QW'(tail_sum);
  assign last_slot = (last_sum >= DEPTH_S) ? QW'(last_sum - DEPTH_S) : QW'(last_sum);

  assign close_pend = (count != '0) && (rd_dur == '0);
  assign close_cur  = (count == '0) && cur_valid && (cur_dur == '0);
  assign close_dur  = (alu_flags.neg || alu_flags.zero) ? '0 : alu_res[TW-1:0];

  assign read_light_mode = (port_reg[7:6] == 2'b11);
  assign read_level      = cur_valid ? ~cur_light : 1'b1;

  ipet_alu #(
    .WIDTH(AW)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .res  (alu_res),
    .flags(alu_flags)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      ST_E_SUM: begin
        alu_a = AW'(now_r);
        alu_b = AW'(recog);
      end
      ST_E_SKEW: begin
        alu_a = AW'(tmp);
        alu_b = AW'(skew);
      end
      ST_E_STOP: begin
        alu_a = AW'(now_r);
        alu_b = AW'(fadeout);
      end
      ST_E_CLOSE: begin
        alu_a   = AW'(tmp);
        alu_b   = (count != '0) ? AW'(rd_start) : AW'(cur_start);
        alu_sub = 1'b1;
      end
      ST_A_END: begin
        alu_a = AW'(cur_start);
        alu_b = AW'(cur_dur);
      end
      ST_A_CHKC, ST_L_CHK: begin
        alu_a   = AW'(now_r);
        alu_b   = AW'(tmp);
        alu_sub = 1'b1;
      end
      ST_A_CHKH, ST_L_TEST: begin
        alu_a   = AW'(now_r);
        alu_b   = AW'(rd_start);
        alu_sub = 1'b1;
      end
      ST_L_END: begin
        alu_a = AW'(rd_start);
        alu_b = AW'(rd_dur);
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // queue port control
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = head;
    wr_en    = 1'b0;
    wr_addr  = tail_slot;
    wr_light = light_r;
    wr_start = start_r;
    wr_dur   = '0;
    unique case (state)
      ST_E_SUM: begin
        rd_en   = (count != '0);
        rd_addr = last_slot;
      end
      ST_E_CLOSE: begin
        wr_en    = close_pend;
        wr_addr  = last_slot;
        wr_light = rd_light;
        wr_start = rd_start;
        wr_dur   = close_dur;
      end
      ST_E_PUSH: begin
        wr_en = (count != DEPTH_C);
      end
      ST_A_END: begin
        rd_en = 1'b1;
      end
      ST_L_ISSUE: begin
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_light[wr_addr] <= wr_light;
      mem_start[wr_addr] <= wr_start;
      mem_dur[wr_addr]   <= wr_dur;
    end
    if (rd_en) begin
      rd_light <= mem_light[rd_addr];
      rd_start <= mem_start[rd_addr];
      rd_dur   <= mem_dur[rd_addr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      recog   <= '0;
      fadeout <= '0;
      skew    <= ipet_pkg::SKEW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipet_pkg::CFG_RECOG:   recog   <= cfg_data;
        ipet_pkg::CFG_FADEOUT: fadeout <= cfg_data;
        ipet_pkg::CFG_SKEW:    skew    <= cfg_data[ipet_pkg::SKEW_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req       <= ipet_pkg::REQ_WRITE;
      port_reg  <= '0;
      cur_valid <= 1'b0;
      cur_light <= 1'b0;
      cur_start <= '0;
      cur_dur   <= '0;
      head      <= '0;
      count     <= '0;
      exp_flag  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req       <= s_tuser;
            now_r     <= TW'(in_cycle);
            light_r   <= in_light;
            res_rdata <= '0;
            res_ev    <= led_toggle;
            res_el    <= led_toggle && wr_next[0];
            res_ec    <= led_toggle ? in_cycle : '0;
            res_ovf   <= 1'b0;
            unique case (s_tuser)
              ipet_pkg::REQ_WRITE: begin
                port_reg <= wr_next;
                state    <= ST_DONE;
              end
              ipet_pkg::REQ_READ: state <= ST_A_END;
              ipet_pkg::REQ_EDGE: state <= ST_E_SUM;
              default:            state <= ST_DONE;
            endcase
          end
        end
        ST_E_SUM: begin
          tmp   <= alu_res[TW:0];
          state <= ST_E_SKEW;
        end
        ST_E_SKEW: begin
          start_r <= alu_res[TW-1:0];
          state   <= ST_E_STOP;
        end
        ST_E_STOP: begin
          tmp <= alu_res[TW:0];
          if (close_pend || close_cur) begin
            state <= ST_E_CLOSE;
          end else begin
            state <= ST_E_PUSH;
          end
        end
        ST_E_CLOSE: begin
          if (close_cur) begin
            cur_dur <= close_dur;
          end
          state <= ST_E_PUSH;
        end
        ST_E_PUSH: begin
          if (count == DEPTH_C) begin
            res_ovf <= 1'b1;
          end else begin
            count <= count + 1'b1;
          end
          state <= ST_A_END;
        end
        ST_A_END: begin
          tmp <= alu_res[TW:0];
          if (cur_valid) begin
            state <= ST_A_CHKC;
          end else begin
            state <= ST_L_ISSUE;
          end
        end
        ST_A_CHKC: begin
          exp_flag <= (cur_dur != '0) && !alu_flags.neg;
          state    <= ST_A_CHKH;
        end
        ST_A_CHKH: begin
          // end the current signal once it times out or the head entry starts
          if (exp_flag || ((count != '0) && !alu_flags.neg)) begin
            cur_valid <= 1'b0;
          end
          state <= ST_L_ISSUE;
        end
        ST_L_ISSUE: begin
          if (cur_valid || (count == '0)) begin
            state <= (req == ipet_pkg::REQ_READ) ? ST_R_FIN : ST_DONE;
          end else begin
            state <= ST_L_TEST;
          end
        end
        ST_L_TEST: begin
          if (alu_flags.neg) begin
            state <= (req == ipet_pkg::REQ_READ) ? ST_R_FIN : ST_DONE;
          end else begin
            head  <= head_inc;
            count <= count - 1'b1;
            if (rd_dur == '0) begin
              cur_valid <= 1'b1;
              cur_light <= rd_light;
              cur_start <= rd_start;
              cur_dur   <= rd_dur;
              state     <= (req == ipet_pkg::REQ_READ) ? ST_R_FIN : ST_DONE;
            end else begin
              state <= ST_L_END;
            end
          end
        end
        ST_L_END: begin
          tmp   <= alu_res[TW:0];
          state <= ST_L_CHK;
        end
        ST_L_CHK: begin
          if (alu_flags.neg) begin
            cur_valid <= 1'b1;
            cur_light <= rd_light;
            cur_start <= rd_start;
            cur_dur   <= rd_dur;
            state     <= (req == ipet_pkg::REQ_READ) ? ST_R_FIN : ST_DONE;
          end else begin
            // drop the expired entry and try the next one
            state <= ST_L_ISSUE;
          end
        end
        ST_R_FIN: begin
          if (read_light_mode) begin
            port_reg  <= {port_reg[7:2], read_level, port_reg[0]};
            res_rdata <= {port_reg[7:2], read_level, port_reg[0]} | ipet_pkg::READ_OR_LIGHT;
          end else begin
            res_rdata <= port_reg | ipet_pkg::READ_OR_IDLE;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {6'd0, res_ovf, res_ec, res_el, res_ev, res_rdata};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for the infrared port edge timeline unit.
module tb;

  localparam logic [ipet_pkg::REQ_W-1:0]     REQ_SPARE = 2'd3;
  localparam logic [ipet_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DEPTH           = 16;
  localparam int ITEMS_PER_PHASE = 450;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 80;
  localparam int CYCLE_LIMIT     = 1500000;

  typedef struct packed {
    bit [7:0]  read_data;
    bit        led_edge;
    bit        led_level;
    bit [30:0] led_cycle;
    bit        dropped;
  } ir_reply_t;

  typedef struct packed {
    bit                           is_reg;
    bit [ipet_pkg::CFG_IDX_W-1:0] reg_idx;
    bit [ipet_pkg::CFG_W-1:0]     reg_val;
    bit [ipet_pkg::REQ_W-1:0]     req;
    bit [7:0]                     wval;
    bit [30:0]                    when;
    bit                           light;
    bit [4:0]                     reps;
    bit                           known;
    ir_reply_t                    want;
  } plan_row_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ipet_pkg::REQ_W-1:0]     s_tuser;
  logic [ipet_pkg::S_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [ipet_pkg::M_DATA_W-1:0]  m_tdata;
  logic                           cfg_we;
  logic [ipet_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ipet_pkg::CFG_W-1:0]     cfg_data;

  infrared_port_edge_timeline_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Port register, received-light playback and its queue
  bit [7:0]                 ir_reg;
  bit                       cur_on;
  bit                       cur_light;
  bit [31:0]                cur_start;
  bit [31:0]                cur_dur;
  bit                       pend_light [DEPTH];
  bit [31:0]                pend_start [DEPTH];
  bit [31:0]                pend_dur   [DEPTH];
  bit [3:0]                 pend_head;
  int                       pend_cnt;
  bit [ipet_pkg::CFG_W-1:0] recog_cfg;
  bit [ipet_pkg::CFG_W-1:0] fade_cfg;
  bit [3:0]                 skew_cfg;

  ir_reply_t replies_due[$];
  plan_row_t plan[$];
  int        mismatches;
  int        cycle_count;
  int        send_idle;
  int        recv_stall;
  bit        hold_off_req;
  bit [30:0] line_now;
  bit        partner_light;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit [31:0] close_span(bit [63:0] edge_t, bit [31:0] start);
    bit [63:0] stop;
    stop = edge_t + 64'(fade_cfg);
    if (stop <= 64'(start)) return '0;
    return 32'(stop - 64'(start));
  endfunction

  function automatic void advance_light(bit [63:0] now);
    bit [3:0] h;
    if (cur_on) begin
      if ((cur_dur != 0 && now >= 64'(cur_start) + 64'(cur_dur)) ||
          (pend_cnt != 0 && now >= 64'(pend_start[pend_head])))
        cur_on = 1'b0;
    end
    // drop queued signals that have already run out; the first live one becomes current
    while (!cur_on && pend_cnt != 0 && now >= 64'(pend_start[pend_head])) begin
      h = pend_head;
      pend_head = pend_head + 4'd1;
      pend_cnt--;
      if (pend_dur[h] == 0 || now < 64'(pend_start[h]) + 64'(pend_dur[h])) begin
        cur_on    = 1'b1;
        cur_light = pend_light[h];
        cur_start = pend_start[h];
        cur_dur   = pend_dur[h];
      end
    end
  endfunction

  function automatic ir_reply_t ir_port_access(bit [ipet_pkg::REQ_W-1:0] req, bit [7:0] wval,
                                               bit [30:0] now, bit light);
    ir_reply_t r;
    bit [7:0]  next_reg;
    bit [63:0] edge_t;
    bit [3:0]  s;
    r = '0;
    edge_t = 64'(now);
    case (req)
      ipet_pkg::REQ_WRITE: begin
        next_reg = {wval[7:2], ir_reg[1], wval[0]};
        if (next_reg[0] != ir_reg[0]) begin
          r.led_edge  = 1'b1;
          r.led_level = next_reg[0];
          r.led_cycle = now;
        end
        ir_reg = next_reg;
      end
      ipet_pkg::REQ_READ: begin
        advance_light(edge_t);
        if (ir_reg[7:6] == 2'b11) begin
          ir_reg[1] = cur_on ? ~cur_light : 1'b1;
          r.read_data = ir_reg | ipet_pkg::READ_OR_LIGHT;
        end else begin
          r.read_data = ir_reg | ipet_pkg::READ_OR_IDLE;
        end
      end
      ipet_pkg::REQ_EDGE: begin
        // close the newest open signal, clamped at zero
        if (pend_cnt != 0) begin
          s = pend_head + 4'(pend_cnt - 1);
          if (pend_dur[s] == 0) pend_dur[s] = close_span(edge_t, pend_start[s]);
        end else if (cur_on && cur_dur == 0) begin
          cur_dur = close_span(edge_t, cur_start);
        end
        if (pend_cnt >= DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          s = pend_head + 4'(pend_cnt);
          pend_light[s] = light;
          pend_start[s] = 32'(edge_t + 64'(recog_cfg) + 64'(skew_cfg));
          pend_dur[s]   = '0;
          pend_cnt++;
        end
        advance_light(edge_t);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(string what, logic [30:0] want, logic [30:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_reply(logic [ipet_pkg::M_DATA_W-1:0] beat);
    ir_reply_t want;
    if (replies_due.size() == 0) begin
      $display("%0t: reply beat expected none, got 'h%0h", $time, beat);
      mismatches++;
    end else begin
      want = replies_due[0];
      replies_due.delete(0);
      compare_field("read_data", 31'(want.read_data), 31'(beat[7:0]));
      compare_field("edge_out_valid", 31'(want.led_edge), 31'(beat[8]));
      compare_field("edge_out_light", 31'(want.led_level), 31'(beat[9]));
      compare_field("edge_out_cycle", want.led_cycle, beat[40:10]);
      compare_field("queue_overflow", 31'(want.dropped), 31'(beat[41]));
      compare_field("padding", '0, 31'(beat[47:42]));
    end
  endtask

  task automatic send_item(bit [ipet_pkg::REQ_W-1:0] req, bit [7:0] wval, bit [30:0] when,
                           bit light, bit known, ir_reply_t want);
    ir_reply_t due;
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tuser  <= req;
    s_tdata  <= {light, when, wval};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = ir_port_access(req, wval, when, light);
    replies_due.insert(replies_due.size(), known ? want : due);
  endtask

  // Hold the sender off until every reply has arrived
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    cfg_we   <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(bit [ipet_pkg::CFG_IDX_W-1:0] idx, bit [ipet_pkg::CFG_W-1:0] val);
    drain_replies();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      ipet_pkg::CFG_RECOG:   recog_cfg = val;
      ipet_pkg::CFG_FADEOUT: fade_cfg  = val;
      ipet_pkg::CFG_SKEW:    skew_cfg  = val[3:0];
      default: ;
    endcase
  endtask

  task automatic add_reg(bit [ipet_pkg::CFG_IDX_W-1:0] idx, bit [ipet_pkg::CFG_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.insert(plan.size(), row);
  endtask

  task automatic add_step(bit [ipet_pkg::REQ_W-1:0] req, bit [7:0] wval, bit [30:0] when,
                          bit light, bit [4:0] reps);
    plan_row_t row;
    row = '0;
    row.req   = req;
    row.wval  = wval;
    row.when  = when;
    row.light = light;
    row.reps  = reps;
    plan.insert(plan.size(), row);
  endtask

  task automatic add_known(bit [ipet_pkg::REQ_W-1:0] req, bit [7:0] wval, bit [30:0] when,
                           bit light, bit [7:0] rdata, bit led_edge, bit led_level,
                           bit [30:0] led_cycle, bit dropped);
    plan_row_t row;
    row = '0;
    row.req   = req;
    row.wval  = wval;
    row.when  = when;
    row.light = light;
    row.reps  = 5'd1;
    row.known = 1'b1;
    row.want  = '{read_data: rdata, led_edge: led_edge, led_level: led_level,
                  led_cycle: led_cycle, dropped: dropped};
    plan.insert(plan.size(), row);
  endtask

  // Timeline-shaped traffic: partner edges near the local clock, bursts that fill
  // the queue, writes that mostly enable light readback, and some raw noise
  task automatic random_item(int step_max);
    bit [ipet_pkg::REQ_W-1:0] req;
    bit [7:0]                 wval;
    bit [30:0]                when;
    int                       pick;
    pick = $urandom_range(0, 99);
    wval = 8'($urandom);
    if (burst_left > 0) begin
      burst_left--;
      line_now = line_now + 31'($urandom_range(0, 3));
    end else begin
      line_now = line_now + 31'($urandom_range(0, step_max));
      if (pick < 3) burst_left = $urandom_range(12, 20);
    end
    when = line_now;
    if (burst_left > 0 || pick < 40) begin
      req = ipet_pkg::REQ_EDGE;
      if ($urandom_range(0, 9) != 0) partner_light = ~partner_light;
      if ($urandom_range(0, 3) == 0) when = line_now - 31'($urandom_range(0, 24));
    end else if (pick < 72) begin
      req = ipet_pkg::REQ_READ;
    end else if (pick < 95) begin
      req = ipet_pkg::REQ_WRITE;
      if ($urandom_range(0, 2) != 0) wval[7:6] = 2'b11;
    end else begin
      req = 2'($urandom);
      when = 31'($urandom);
    end
    send_item(req, wval, when, partner_light, 1'b0, '0);
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) check_reply(m_tdata);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int phase_idle  [4];
    int phase_stall [4];
    int step_max;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = '0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    mismatches    = 0;
    send_idle     = 0;
    recv_stall    = 0;
    hold_off_req  = 1'b0;
    burst_left    = 0;
    partner_light = 1'b0;
    phase_idle  = '{0, 88, 0, 20};
    phase_stall = '{0, 0, 88, 20};

    ir_reg    = '0;
    cur_on    = 1'b0;
    cur_light = 1'b0;
    cur_start = '0;
    cur_dur   = '0;
    pend_head = '0;
    pend_cnt  = 0;
    recog_cfg = '0;
    fade_cfg  = '0;
    skew_cfg  = ipet_pkg::SKEW_RESET;

    add_known(ipet_pkg::REQ_READ, 8'h00, 31'd0, 1'b0, 8'h3E, 1'b0, 1'b0, 31'd0, 1'b0);
    add_known(REQ_SPARE, 8'hFF, 31'h7FFFFFFF, 1'b1, 8'h00, 1'b0, 1'b0, 31'd0, 1'b0);
    add_known(ipet_pkg::REQ_WRITE, 8'hFF, 31'd100, 1'b0, 8'h00, 1'b1, 1'b1, 31'd100, 1'b0);
    // light bits enabled, nothing received yet: bit 1 reads as one
    add_known(ipet_pkg::REQ_READ, 8'h00, 31'd110, 1'b0, 8'hFF, 1'b0, 1'b0, 31'd0, 1'b0);
    add_known(ipet_pkg::REQ_WRITE, 8'h00, 31'h7FFFFFFF, 1'b0, 8'h00, 1'b1, 1'b0,
              31'h7FFFFFFF, 1'b0);
    add_step(ipet_pkg::REQ_WRITE, 8'hC1, 31'd200, 1'b0, 5'd1);
    add_known(ipet_pkg::REQ_WRITE, 8'hC3, 31'd300, 1'b0, 8'h00, 1'b0, 1'b0, 31'd0, 1'b0);
    add_step(ipet_pkg::REQ_EDGE, 8'h00, 31'd1000, 1'b1, 5'd1);
    add_step(ipet_pkg::REQ_READ, 8'h00, 31'd1004, 1'b0, 5'd1);
    add_step(ipet_pkg::REQ_EDGE, 8'h00, 31'd1010, 1'b0, 5'd1);
    // edge earlier than the newest start: its duration clamps to zero
    add_step(ipet_pkg::REQ_EDGE, 8'h00, 31'd1000, 1'b1, 5'd1);
    add_step(ipet_pkg::REQ_READ, 8'h00, 31'd1020, 1'b0, 5'd1);
    add_reg(ipet_pkg::CFG_RECOG, 16'hFFFF);
    add_reg(ipet_pkg::CFG_FADEOUT, 16'hFFFF);
    add_reg(ipet_pkg::CFG_SKEW, 16'hFFFF);
    add_reg(CFG_SPARE, 16'hFFFF);
    // far-future starts keep the queue from draining until it is full
    add_step(ipet_pkg::REQ_EDGE, 8'h00, 31'd5000, 1'b0, 5'd16);
    add_known(ipet_pkg::REQ_EDGE, 8'h00, 31'd5000, 1'b1, 8'h00, 1'b0, 1'b0, 31'd0, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        repeat (plan[i].reps)
          send_item(plan[i].req, plan[i].wval, plan[i].when, plan[i].light,
                    plan[i].known, plan[i].want);
      end
    end

    line_now = 31'($urandom_range(0, 32'h4000_0000));
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(ipet_pkg::CFG_RECOG, 16'd0);
          write_reg(ipet_pkg::CFG_FADEOUT, 16'd0);
          write_reg(ipet_pkg::CFG_SKEW, 16'd0);
        end
        1: begin
          write_reg(ipet_pkg::CFG_RECOG, 16'($urandom_range(0, 300)));
          write_reg(ipet_pkg::CFG_FADEOUT, 16'($urandom_range(0, 3000)));
          write_reg(ipet_pkg::CFG_SKEW, 16'($urandom_range(0, 15)));
        end
        2: begin
          write_reg(ipet_pkg::CFG_RECOG, 16'hFFFF);
          write_reg(ipet_pkg::CFG_FADEOUT, 16'hFFFF);
          write_reg(ipet_pkg::CFG_SKEW, 16'd15);
        end
        default: begin
          write_reg(ipet_pkg::CFG_RECOG, 16'($urandom));
          write_reg(ipet_pkg::CFG_FADEOUT, 16'($urandom));
          write_reg(ipet_pkg::CFG_SKEW, 16'($urandom));
        end
      endcase
      send_idle  = phase_idle[ph];
      recv_stall = phase_stall[ph];
      step_max   = (int'(recog_cfg) + int'(fade_cfg)) / 8 + 20;
      if (ph == 0 || ph == 3) hold_off_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 150 == 149) drain_replies();
        random_item(step_max);
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### infrared_port_edge_timeline_unit.f
hdl/ipet_pkg.sv
hdl/ipet_alu.sv
hdl/infrared_port_edge_timeline_unit.sv
tb/tb.sv
